>>> hw/rtl/rrf_pkg.sv
// Shared constants and helper functions for the register rename free list unit.
// No dependencies; imported by the top level.
package rrf_pkg;

  // Register file sizes.
  localparam int unsigned ARCH_REGS = 50;
  localparam int unsigned PHYS_REGS = 2048;
  localparam int unsigned FLAG_REG  = ARCH_REGS - 1;

  // Index widths of the stores and counters.
  localparam int unsigned AW = $clog2(ARCH_REGS);
  localparam int unsigned PW = $clog2(PHYS_REGS);
  localparam int unsigned CW = $clog2(PHYS_REGS + 1);

  // Fixed widths of the request fields.
  localparam int unsigned AIW = 7;
  localparam int unsigned PIW = 12;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_UNDER = 2'd1;
  localparam logic [1:0] ST_OVER  = 2'd2;

  // Architectural index is valid when it is non-negative and in range.
  function automatic logic arch_ok(logic [AIW-1:0] a);
    logic ok;
    ok = !a[AIW-1] && ({1'b0, a[AIW-2:0]} < AIW'(ARCH_REGS));
    return ok;
  endfunction

  // Physical index on commit is valid when non-negative and in range.
  function automatic logic phys_ok(logic [PIW-1:0] p);
    logic ok;
    ok = !p[PIW-1] && ({1'b0, p[PIW-2:0]} < PIW'(PHYS_REGS));
    return ok;
  endfunction

  // Circular increment of a free list pointer.
  function automatic logic [PW-1:0] ptr_inc(logic [PW-1:0] p);
    logic [PW-1:0] n;
    n = (p == PW'(PHYS_REGS - 1)) ? '0 : p + PW'(1);
    return n;
  endfunction

endpackage

>>> hw/rtl/rrf_ram.sv
// Generic synchronous RAM with one write port and two registered read ports.
// No dependencies; used for the map table and the free list storage.
module rrf_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 8,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_a_i,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_a_o,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read ports.
  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

>>> hw/rtl/register_rename_free_list_unit.sv
// Top level of the register rename unit: map table, FIFO free list and sequencer.
// Depends on rrf_pkg and rrf_ram.
//
// Renames micro-ops through a 50-entry map table into 2048 physical registers
// and keeps the unallocated registers in a circular free list; the last
// architectural register is the condition flag. After reset the unit loads
// both memories (map entry i gets i, free list slot i gets i+50) and accepts
// no request until that pass is done. Then a rename request steps through
// S_RDS and S_RDD (reads on the map table's two read ports), S_EVAL, and
// S_WR2 when both the destination and the flag are written, since the map
// table has a single write port; a commit request steps through S_CMT, and
// S_WR2 when two registers are pushed through the single free-list write
// port. Both then wait in S_OUT until the output register is free and
// return to idle before the next request. One request is in flight at a
// time; a finished result waits in the output register while the next
// request is accepted. Underflow on rename reports status 1 and overflow
// on commit reports status 2, and neither changes any state.
module register_rename_free_list_unit
  import rrf_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic           kind_i,
  input  logic [AIW-1:0] src1_arch_i,
  input  logic [AIW-1:0] src2_arch_i,
  input  logic [AIW-1:0] dest_arch_i,
  input  logic           writes_flag_i,
  input  logic           reads_flag_i,
  input  logic [PIW-1:0] freed_dest_i,
  input  logic [PIW-1:0] freed_flag_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [PW-1:0]  src1_phys_o,
  output logic [PW-1:0]  src2_phys_o,
  output logic [PW-1:0]  dest_phys_new_o,
  output logic [PW-1:0]  dest_phys_old_o,
  output logic [PW-1:0]  flag_phys_new_o,
  output logic [PW-1:0]  flag_phys_old_o,
  output logic [1:0]     status_o
);

  // Sequencer states.
  localparam logic [2:0] S_INIT = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_RDS  = 3'd2;
  localparam logic [2:0] S_RDD  = 3'd3;
  localparam logic [2:0] S_EVAL = 3'd4;
  localparam logic [2:0] S_CMT  = 3'd5;
  localparam logic [2:0] S_WR2  = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0]     state_q, state_d;
  logic [PW-1:0]  init_idx_q, init_idx_d;
  logic [PW-1:0]  head_q, head_d;
  logic [PW-1:0]  tail_q, tail_d;
  logic [CW-1:0]  count_q, count_d;

  // Captured request.
  logic           kind_q, wf_q;
  logic [AIW-1:0] s1_q, s2_q, d_q;
  logic [PIW-1:0] fd_q, ff_q;

  // Result being built.
  logic [PW-1:0]  res_src1_q, res_src1_d;
  logic [PW-1:0]  res_src2_q, res_src2_d;
  logic [PW-1:0]  res_dnew_q, res_dnew_d;
  logic [PW-1:0]  res_dold_q, res_dold_d;
  logic [PW-1:0]  res_fnew_q, res_fnew_d;
  logic [PW-1:0]  res_fold_q, res_fold_d;
  logic [1:0]     res_st_q, res_st_d;

  // Output register.
  logic           out_valid_q, out_valid_d;
  logic           out_load;

  // Memory ports.
  logic           map_we;
  logic [AW-1:0]  map_waddr, map_ra, map_rb;
  logic [PW-1:0]  map_wdata, map_rd_a, map_rd_b;
  logic           fifo_we;
  logic [PW-1:0]  fifo_waddr, fifo_wdata, fifo_ra, fifo_rb, fifo_rd_a, fifo_rd_b;

  // Decoded request fields.
  logic           s1v, s2v, dv, fdv, ffv, d_is_flag;
  logic [1:0]     pop_need, push_need;
  logic           underflow, overflow;
  logic [CW:0]    count_after_push;
  logic           in_fire;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  assign s1v       = arch_ok(s1_q);
  assign s2v       = arch_ok(s2_q);
  assign dv        = arch_ok(d_q);
  assign fdv       = phys_ok(fd_q);
  assign ffv       = phys_ok(ff_q);
  assign d_is_flag = (d_q[AW-1:0] == AW'(FLAG_REG));

  // Free list occupancy checks.
  assign pop_need         = {1'b0, dv} + {1'b0, wf_q};
  assign push_need        = {1'b0, fdv} + {1'b0, ffv};
  assign underflow        = (count_q < CW'(pop_need));
  assign count_after_push = {1'b0, count_q} + (CW + 1)'(push_need);
  assign overflow         = (count_after_push > (CW + 1)'(PHYS_REGS));

  rrf_ram #(
    .DEPTH(ARCH_REGS),
    .WIDTH(PW)
  ) u_map (
    .clk_i    (clk_i),
    .we_i     (map_we),
    .waddr_i  (map_waddr),
    .wdata_i  (map_wdata),
    .raddr_a_i(map_ra),
    .raddr_b_i(map_rb),
    .rdata_a_o(map_rd_a),
    .rdata_b_o(map_rd_b)
  );

  rrf_ram #(
    .DEPTH(PHYS_REGS),
    .WIDTH(PW)
  ) u_fifo (
    .clk_i    (clk_i),
    .we_i     (fifo_we),
    .waddr_i  (fifo_waddr),
    .wdata_i  (fifo_wdata),
    .raddr_a_i(fifo_ra),
    .raddr_b_i(fifo_rb),
    .rdata_a_o(fifo_rd_a),
    .rdata_b_o(fifo_rd_b)
  );

  // Sequencer, memory port control and result assembly.
  always_comb begin
    state_d    = state_q;
    init_idx_d = init_idx_q;
    head_d     = head_q;
    tail_d     = tail_q;
    count_d    = count_q;
    res_src1_d = res_src1_q;
    res_src2_d = res_src2_q;
    res_dnew_d = res_dnew_q;
    res_dold_d = res_dold_q;
    res_fnew_d = res_fnew_q;
    res_fold_d = res_fold_q;
    res_st_d   = res_st_q;
    out_load   = 1'b0;
    map_we     = 1'b0;
    map_waddr  = d_q[AW-1:0];
    map_wdata  = fifo_rd_a;
    map_ra     = s1_q[AW-1:0];
    map_rb     = s2_q[AW-1:0];
    fifo_we    = 1'b0;
    fifo_waddr = tail_q;
    fifo_wdata = fd_q[PW-1:0];
    fifo_ra    = head_q;
    fifo_rb    = ptr_inc(head_q);

    unique case (state_q)
      S_INIT: begin
        // Load the reset contents of both memories, one slot per cycle.
        fifo_we    = 1'b1;
        fifo_waddr = init_idx_q;
        fifo_wdata = init_idx_q + PW'(ARCH_REGS);
        map_we     = (init_idx_q < PW'(ARCH_REGS));
        map_waddr  = init_idx_q[AW-1:0];
        map_wdata  = init_idx_q;
        init_idx_d = init_idx_q + PW'(1);
        if (init_idx_q == PW'(PHYS_REGS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          state_d = kind_i ? S_CMT : S_RDS;
        end
      end
      S_RDS: begin
        // Read both source mappings.
        state_d = S_RDD;
      end
      S_RDD: begin
        // Sources are back; read dest and flag mappings and the two list heads.
        res_src1_d = s1v ? map_rd_a : '0;
        res_src2_d = s2v ? map_rd_b : '0;
        map_ra     = d_q[AW-1:0];
        map_rb     = AW'(FLAG_REG);
        state_d    = S_EVAL;
      end
      S_EVAL: begin
        res_dold_d = dv ? map_rd_a : '0;
        if (underflow) begin
          res_st_d   = ST_UNDER;
          res_dnew_d = '0;
          res_fnew_d = '0;
          res_fold_d = map_rd_b;
          state_d    = S_OUT;
        end else begin
          res_st_d   = ST_OK;
          res_dnew_d = dv ? fifo_rd_a : '0;
          res_fnew_d = wf_q ? (dv ? fifo_rd_b : fifo_rd_a) : '0;
          res_fold_d = (dv && d_is_flag) ? fifo_rd_a : map_rd_b;
          count_d    = count_q - CW'(pop_need);
          unique case (pop_need)
            2'd2:    head_d = ptr_inc(ptr_inc(head_q));
            2'd1:    head_d = ptr_inc(head_q);
            default: head_d = head_q;
          endcase
          // First map update: the dest if there is one, else the flag.
          if (dv) begin
            map_we    = 1'b1;
            map_waddr = d_q[AW-1:0];
            map_wdata = fifo_rd_a;
          end else if (wf_q) begin
            map_we    = 1'b1;
            map_waddr = AW'(FLAG_REG);
            map_wdata = fifo_rd_a;
          end
          state_d = (dv && wf_q) ? S_WR2 : S_OUT;
        end
      end
      S_CMT: begin
        res_src1_d = '0;
        res_src2_d = '0;
        res_dnew_d = '0;
        res_dold_d = '0;
        res_fnew_d = '0;
        res_fold_d = '0;
        if (overflow) begin
          res_st_d = ST_OVER;
          state_d  = S_OUT;
        end else begin
          res_st_d = ST_OK;
          count_d  = count_after_push[CW-1:0];
          // First push: the dest register if there is one, else the flag.
          if (fdv || ffv) begin
            fifo_we    = 1'b1;
            fifo_waddr = tail_q;
            fifo_wdata = fdv ? fd_q[PW-1:0] : ff_q[PW-1:0];
            tail_d     = ptr_inc(tail_q);
          end
          state_d = (fdv && ffv) ? S_WR2 : S_OUT;
        end
      end
      S_WR2: begin
        // Second write: flag mapping on rename, flag register push on commit.
        if (kind_q) begin
          fifo_we    = 1'b1;
          fifo_waddr = tail_q;
          fifo_wdata = ff_q[PW-1:0];
          tail_d     = ptr_inc(tail_q);
        end else begin
          map_we    = 1'b1;
          map_waddr = AW'(FLAG_REG);
          map_wdata = res_fnew_q;
        end
        state_d = S_OUT;
      end
      S_OUT: begin
        // Hand the result over once the output register is free.
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = out_load ? 1'b1 : (out_valid_q && !out_ready_i);

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      init_idx_q  <= '0;
      head_q      <= '0;
      tail_q      <= PW'(PHYS_REGS - ARCH_REGS);
      count_q     <= CW'(PHYS_REGS - ARCH_REGS);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      init_idx_q  <= init_idx_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Request capture and result payload.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      kind_q <= kind_i;
      s1_q   <= src1_arch_i;
      s2_q   <= src2_arch_i;
      d_q    <= dest_arch_i;
      wf_q   <= writes_flag_i;
      fd_q   <= freed_dest_i;
      ff_q   <= freed_flag_i;
    end
    res_src1_q <= res_src1_d;
    res_src2_q <= res_src2_d;
    res_dnew_q <= res_dnew_d;
    res_dold_q <= res_dold_d;
    res_fnew_q <= res_fnew_d;
    res_fold_q <= res_fold_d;
    res_st_q   <= res_st_d;
    if (out_load) begin
      src1_phys_o     <= res_src1_q;
      src2_phys_o     <= res_src2_q;
      dest_phys_new_o <= res_dnew_q;
      dest_phys_old_o <= res_dold_q;
      flag_phys_new_o <= res_fnew_q;
      flag_phys_old_o <= res_fold_q;
      status_o        <= res_st_q;
    end
  end

  assign out_valid_o = out_valid_q;

  // The flag read is informational only and does not affect renaming.
  logic unused_reads_flag;
  assign unused_reads_flag = reads_flag_i;

  // The free list never holds more registers than exist.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(PHYS_REGS))
    else $error("free list count exceeds the number of physical registers");

  // Registers leave the free list only in the evaluate step of a rename.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q < $past(count_q)) |-> ($past(state_q) == S_EVAL))
    else $error("free list shrank outside rename evaluation");

  // An underflow result never reports newly allocated registers.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_UNDER) |->
      (dest_phys_new_o == '0 && flag_phys_new_o == '0))
    else $error("underflow result carries an allocation");

  // An overflow leaves the free list pointers and count untouched.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMT && overflow) |=> ($stable(tail_q) && $stable(count_q)))
    else $error("overflowing commit changed the free list");

endmodule
